// ===== rtl/emt_pkg.sv =====
// Package for the multiturn encoder tracker: widths, fixed-point constants,
// state encoding and the output saturation helper.
// No dependencies.
package emt_pkg;

	localparam int COUNT_W = 16;
	localparam int TURN_W  = 24;
	localparam int DT_W    = 24;
	localparam int OUT_W   = 48;
	localparam int MUL_A_W = 25;
	localparam int MUL_B_W = 21;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = 68;
	localparam int ITER_W  = 6;

	localparam logic [COUNT_W-1:0] CPR_RESET = 16'd4096;

	// 2*pi in Q32, split into two operands for the shared multiplier
	localparam logic [34:0] TWO_PI_Q32    = 35'd26986075409;
	localparam logic [19:0] TWO_PI_Q32_LO = TWO_PI_Q32[19:0];
	localparam logic [14:0] TWO_PI_Q32_HI = TWO_PI_Q32[34:20];
	// 2*pi in Q16, rounded half up
	localparam logic [34:0] TWO_PI_SUM    = TWO_PI_Q32 + 35'd32768;
	localparam logic [18:0] TWO_PI_FRAC   = TWO_PI_SUM[34:16];
	localparam logic [19:0] US_PER_S      = 20'd1000000;

	localparam logic [ITER_W-1:0] ANG_STEPS = 6'd36;
	localparam logic [ITER_W-1:0] VEL_STEPS = 6'd48;

	localparam logic signed [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W-1){1'b1}}};
	localparam logic signed [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W-1){1'b0}}};
	localparam logic signed [OUT_W-1:0]  OUT_MAX  = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0]  OUT_MIN  = {1'b1, {(OUT_W-1){1'b0}}};

	localparam logic KIND_UPDATE   = 1'b0;
	localparam logic KIND_RESET    = 1'b1;
	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_MUL_ACC,
		ST_ANG_LOAD,
		ST_DIV_ANG,
		ST_TURN_MUL,
		ST_POS,
		ST_DIFF,
		ST_MAG,
		ST_V_LO,
		ST_V_HI,
		ST_V_ACC,
		ST_V_LOAD,
		ST_DIV_VEL,
		ST_VEL,
		ST_DONE
	} state_t;

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [OUT_W:0] v);
		logic signed [OUT_W-1:0] r;
		if (v[OUT_W] != v[OUT_W-1]) begin
			r = v[OUT_W] ? OUT_MIN : OUT_MAX;
		end else begin
			r = v[OUT_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/encoder_multiturn_tracker.sv =====
// Multiturn encoder tracker top level: turn unwrapping, Q16 radian position
// and rounded velocity, built on one shared multiplier and one radix-2 divider.
// Depends on emt_pkg.

// An update item passes through the multiply, divide and position states
// (the velocity division is skipped when the speed saturates) and waits in
// ST_DONE until the output register is free, then is registered there; the next
// item is taken once the result is in the output register. The divider
// retires one quotient bit per cycle: 36 steps turn the count into a
// fraction of a turn and 48 steps divide the scaled position change by the
// sample interval; a 25x21 multiplier is used five times around those steps.
// Reset items and rejected updates (zero counts per turn or zero interval)
// go straight to ST_DONE. The counts-per-turn register is written through
// cfg_wr_en and cfg_wr_data and must only change while no item is in flight.
module encoder_multiturn_tracker
	import emt_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [COUNT_W-1:0]        cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      kind,
	input  logic [COUNT_W-1:0]        enc_count,
	input  logic [DT_W-1:0]           time_step_us,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [OUT_W-1:0]   position,
	output logic signed [OUT_W-1:0]   velocity,
	output logic                      status
);

	state_t state_q, state_d;

	logic [COUNT_W-1:0]        cpr_q;
	logic [COUNT_W-1:0]        last_count_q;
	logic signed [TURN_W-1:0]  turn_q;
	logic signed [OUT_W-1:0]   last_pos_q;

	logic [COUNT_W-1:0]        count_q;
	logic [DT_W-1:0]           dt_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic [ACC_W-1:0]          acc_q;
	logic [DT_W-1:0]           rem_q;
	logic [OUT_W-1:0]          dvd_q;
	logic [DT_W-1:0]           divisor_q;
	logic [ITER_W-1:0]         iter_q;
	logic signed [OUT_W-1:0]   pos_q;
	logic signed [OUT_W:0]     diff_q;
	logic                      neg_q;
	logic [OUT_W-1:0]          mag_q;
	logic                      vsat_q;
	logic signed [OUT_W-1:0]   res_pos_q;
	logic signed [OUT_W-1:0]   res_vel_q;
	logic                      res_status_q;
	logic                      out_valid_q;

	logic in_xfer, out_load, upd_ok;

	assign in_xfer  = in_valid && in_ready;
	assign upd_ok   = (cpr_q != '0) && (time_step_us != '0);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (kind == KIND_RESET || !upd_ok) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_MUL_LO;
					end
				end
			end
			ST_MUL_LO:   state_d = ST_MUL_HI;
			ST_MUL_HI:   state_d = ST_MUL_ACC;
			ST_MUL_ACC:  state_d = ST_ANG_LOAD;
			ST_ANG_LOAD: state_d = ST_DIV_ANG;
			ST_DIV_ANG: begin
				if (iter_q == ITER_W'(1)) state_d = ST_TURN_MUL;
			end
			ST_TURN_MUL: state_d = ST_POS;
			ST_POS:      state_d = ST_DIFF;
			ST_DIFF:     state_d = ST_MAG;
			ST_MAG:      state_d = ST_V_LO;
			ST_V_LO:     state_d = ST_V_HI;
			ST_V_HI:     state_d = ST_V_ACC;
			ST_V_ACC:    state_d = ST_V_LOAD;
			ST_V_LOAD: begin
				if ({4'b0, acc_q[ACC_W-1:OUT_W]} >= dt_q) begin
					state_d = ST_VEL;
				end else begin
					state_d = ST_DIV_VEL;
				end
			end
			ST_DIV_VEL: begin
				if (iter_q == ITER_W'(1)) state_d = ST_VEL;
			end
			ST_VEL:      state_d = ST_DONE;
			ST_DONE: begin
				if (out_load) state_d = ST_IDLE;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// Shared multiplier operands
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_p;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MUL_LO: begin
				mul_a = $signed({9'b0, count_q});
				mul_b = $signed({1'b0, TWO_PI_Q32_LO});
			end
			ST_MUL_HI: begin
				mul_a = $signed({9'b0, count_q});
				mul_b = $signed({6'b0, TWO_PI_Q32_HI});
			end
			ST_TURN_MUL: begin
				mul_a = {turn_q[TURN_W-1], turn_q};
				mul_b = $signed({2'b0, TWO_PI_FRAC});
			end
			ST_V_LO: begin
				mul_a = $signed({1'b0, mag_q[23:0]});
				mul_b = $signed({1'b0, US_PER_S});
			end
			ST_V_HI: begin
				mul_a = $signed({1'b0, mag_q[47:24]});
				mul_b = $signed({1'b0, US_PER_S});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Divider step: shift in one dividend bit, subtract when it fits
	logic [DT_W:0]   trial, trial_sub;
	logic            fits;
	logic [DT_W-1:0] rem_next;

	assign trial     = {rem_q, dvd_q[OUT_W-1]};
	assign trial_sub = trial - {1'b0, divisor_q};
	assign fits      = trial >= {1'b0, divisor_q};
	assign rem_next  = fits ? trial_sub[DT_W-1:0] : trial[DT_W-1:0];

	// Turn unwrapping compare
	logic signed [COUNT_W+1:0] delta, half;

	assign delta = $signed({2'b0, enc_count}) - $signed({2'b0, last_count_q});
	assign half  = $signed({3'b0, cpr_q[COUNT_W-1:1]});

	// Position, difference and velocity terms
	logic signed [OUT_W:0]   pos_sum;
	logic [OUT_W:0]          diff_neg;
	logic [OUT_W-1:0]        quot_neg;
	logic signed [OUT_W-1:0] vel_val;

	assign pos_sum  = {{3{prod_q[PROD_W-1]}}, prod_q} + $signed({13'b0, dvd_q[35:0]});
	assign diff_neg = -diff_q;
	assign quot_neg = -dvd_q;

	always_comb begin
		if (vsat_q) begin
			vel_val = neg_q ? OUT_MIN : OUT_MAX;
		end else if (neg_q) begin
			vel_val = dvd_q[OUT_W-1] ? OUT_MIN : $signed(quot_neg);
		end else begin
			vel_val = dvd_q[OUT_W-1] ? OUT_MAX : $signed(dvd_q);
		end
	end

	// Architectural state and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q        <= CPR_RESET;
			last_count_q <= '0;
			turn_q       <= '0;
			last_pos_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) cpr_q <= cfg_wr_data;
			if (in_xfer) begin
				if (kind == KIND_RESET) begin
					last_count_q <= enc_count;
					turn_q       <= '0;
					last_pos_q   <= '0;
				end else if (upd_ok) begin
					last_count_q <= enc_count;
					if (delta > half) begin
						if (turn_q != TURN_MIN) turn_q <= turn_q - TURN_W'(1);
					end else if (delta < -half) begin
						if (turn_q != TURN_MAX) turn_q <= turn_q + TURN_W'(1);
					end
				end
			end
			if (state_q == ST_VEL) last_pos_q <= pos_q;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (in_xfer) begin
			count_q      <= enc_count;
			dt_q         <= time_step_us;
			res_pos_q    <= '0;
			res_vel_q    <= '0;
			res_status_q <= (kind == KIND_RESET || upd_ok) ? STATUS_OK : STATUS_REJECT;
			vsat_q       <= 1'b0;
		end
		unique case (state_q)
			ST_MUL_HI: begin
				acc_q <= {23'b0, prod_q[44:0]} + {37'b0, cpr_q, 15'b0};
			end
			ST_MUL_ACC: begin
				acc_q <= acc_q + {3'b0, prod_q[44:0], 20'b0};
			end
			ST_ANG_LOAD: begin
				rem_q     <= '0;
				dvd_q     <= {acc_q[51:16], 12'b0};
				divisor_q <= {8'b0, cpr_q};
				iter_q    <= ANG_STEPS;
			end
			ST_DIV_ANG, ST_DIV_VEL: begin
				rem_q  <= rem_next;
				dvd_q  <= {dvd_q[OUT_W-2:0], fits};
				iter_q <= iter_q - ITER_W'(1);
			end
			ST_POS: begin
				pos_q <= sat_out(pos_sum);
			end
			ST_DIFF: begin
				diff_q <= {pos_q[OUT_W-1], pos_q} - {last_pos_q[OUT_W-1], last_pos_q};
			end
			ST_MAG: begin
				neg_q <= diff_q[OUT_W];
				mag_q <= diff_q[OUT_W] ? diff_neg[OUT_W-1:0] : diff_q[OUT_W-1:0];
			end
			ST_V_HI: begin
				// add half the interval for round-half-away on the magnitude
				acc_q <= {23'b0, prod_q[44:0]} + {45'b0, dt_q[DT_W-1:1]};
			end
			ST_V_ACC: begin
				acc_q <= acc_q + {prod_q[43:0], 24'b0};
			end
			ST_V_LOAD: begin
				// quotient would not fit in 48 bits: saturate without dividing
				vsat_q    <= {4'b0, acc_q[ACC_W-1:OUT_W]} >= dt_q;
				rem_q     <= {4'b0, acc_q[ACC_W-1:OUT_W]};
				dvd_q     <= acc_q[OUT_W-1:0];
				divisor_q <= dt_q;
				iter_q    <= VEL_STEPS;
			end
			ST_VEL: begin
				res_pos_q    <= pos_q;
				res_vel_q    <= vel_val;
				res_status_q <= STATUS_OK;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			position <= res_pos_q;
			velocity <= res_vel_q;
			status   <= res_status_q;
		end
	end

	assign out_valid = out_valid_q;

	// Turn counter moves only when an item is transferred
	a_turn_on_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		(turn_q != $past(turn_q)) |-> $past(in_xfer))
		else $error("turn counter changed without an input transfer");

	// Divider remainder stays below its divisor while stepping
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_ANG || state_q == ST_DIV_VEL) |-> (rem_q < divisor_q))
		else $error("divider remainder not below divisor");

	// Rejected updates report zero position and velocity
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STATUS_REJECT) |-> (position == '0 && velocity == '0))
		else $error("rejected result carries nonzero data");

	// Stored position follows only a finished update or a reset item
	a_last_pos_src: assert property (@(posedge clk) disable iff (!arst_n)
		(last_pos_q != $past(last_pos_q)) |-> $past(state_q == ST_VEL || in_xfer))
		else $error("last position changed outside an update");

endmodule

// ===== tb/encoder_multiturn_tracker_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for encoder_multiturn_tracker: a queue-fed sender, a checking
// receiver and a cycle-accurate-free predictor of position, velocity and status.
// Depends on emt_pkg and the encoder_multiturn_tracker RTL.
module encoder_multiturn_tracker_tb;
	import emt_pkg::*;

	localparam int TURN_BITS = TURN_W;
	localparam int MAX_REPORTS = 10;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 120;

	localparam logic [63:0] PI2_Q32 = 64'd26986075409;
	localparam logic [63:0] PI2_Q16 = (PI2_Q32 + 64'd32768) >> 16;
	localparam logic [63:0] MICROS_PER_SEC = 64'd1000000;
	localparam longint OUT_HI = (longint'(1) <<< (OUT_W - 1)) - 1;
	localparam longint OUT_LO = -OUT_HI - 1;
	localparam longint TURN_HI = (longint'(1) <<< (TURN_BITS - 1)) - 1;
	localparam longint TURN_LO = -TURN_HI - 1;
	localparam logic [63:0] VEL_Q_CAP = 64'(OUT_HI) / MICROS_PER_SEC + 64'd1;

	typedef struct packed {
		logic               op;
		logic [COUNT_W-1:0] count;
		logic [DT_W-1:0]    dt;
	} track_item_t;

	typedef struct packed {
		logic [OUT_W-1:0] pos;
		logic [OUT_W-1:0] vel;
		logic             stat;
	} track_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [COUNT_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic kind = KIND_UPDATE;
	logic [COUNT_W-1:0] enc_count = '0;
	logic [DT_W-1:0] time_step_us = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [OUT_W-1:0] position;
	logic signed [OUT_W-1:0] velocity;
	logic status;

	track_item_t   pending_samples[$];
	track_result_t expected_track[$];

	// predictor copy of the register and the tracking state
	logic [COUNT_W-1:0] trk_cpr = CPR_RESET;
	logic [COUNT_W-1:0] trk_last_count = '0;
	longint trk_turns = 0;
	longint trk_last_pos = 0;
	longint trk_last_vel = 0;

	int walk_count = 0;
	int items_sent = 0;
	int results_seen = 0;
	int hold_left = 0;
	int mismatch_count = 0;
	int quiet_cycles = 0;

	encoder_multiturn_tracker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.enc_count    (enc_count),
		.time_step_us (time_step_us),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.position     (position),
		.velocity     (velocity),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Advance the tracking state by one sample and return the result it produces.
	function automatic track_result_t track_sample(input logic op, input logic [COUNT_W-1:0] cnt,
			input logic [DT_W-1:0] dt);
		track_result_t r;
		longint delta, half_rev, frac, pos, diff, vel;
		logic [63:0] num, den, mag, q, rem, v, dt64;
		logic neg;
		r.pos = '0;
		r.vel = '0;
		r.stat = STATUS_OK;
		dt64 = {40'd0, dt};
		if (op == KIND_RESET) begin
			trk_last_count = cnt;
			trk_turns = 0;
			trk_last_pos = 0;
			trk_last_vel = 0;
		end else if (trk_cpr == '0 || dt == '0) begin
			r.stat = STATUS_REJECT;
		end else begin
			delta = longint'(cnt) - longint'(trk_last_count);
			half_rev = longint'(trk_cpr >> 1);
			// a forward jump past half a turn is a backward wrap, and vice versa
			if (delta > half_rev) begin
				if (trk_turns > TURN_LO) trk_turns--;
			end else if (delta < -half_rev) begin
				if (trk_turns < TURN_HI) trk_turns++;
			end
			trk_last_count = cnt;

			num = {48'd0, cnt} * PI2_Q32 + ({48'd0, trk_cpr} << 15);
			den = {48'd0, trk_cpr} << 16;
			frac = longint'(num / den);
			pos = trk_turns * longint'(PI2_Q16) + frac;
			if (pos > OUT_HI) pos = OUT_HI;
			if (pos < OUT_LO) pos = OUT_LO;

			// round the speed magnitude half away from zero, then clamp
			diff = pos - trk_last_pos;
			neg = diff < 0;
			mag = neg ? 64'(-diff) : 64'(diff);
			q = mag / dt64;
			rem = mag % dt64;
			if (q > VEL_Q_CAP) begin
				v = 64'(OUT_HI) + 64'd1;
			end else begin
				v = q * MICROS_PER_SEC + (rem * MICROS_PER_SEC + dt64 / 64'd2) / dt64;
			end
			if (neg) begin
				vel = (v > 64'(OUT_HI) + 64'd1) ? OUT_LO : -longint'(v);
			end else begin
				vel = (v > 64'(OUT_HI)) ? OUT_HI : longint'(v);
			end

			trk_last_pos = pos;
			trk_last_vel = vel;
			r.pos = OUT_W'(pos);
			r.vel = OUT_W'(vel);
		end
		return r;
	endfunction

	// Sender: predict on each transfer, then offer the next queued sample.
	always @(posedge clk or negedge arst_n) begin : sample_driver
		track_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= KIND_UPDATE;
			enc_count <= '0;
			time_step_us <= '0;
			items_sent <= 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_track.push_back(track_sample(kind, enc_count, time_step_us));
			end
			if (!in_valid || in_ready) begin
				if (pending_samples.size() != 0 &&
						((items_sent >= 700 && items_sent < 1000) || $urandom_range(0, 99) >= 27)) begin
					nxt = pending_samples.pop_front();
					kind <= nxt.op;
					enc_count <= nxt.count;
					time_step_us <= nxt.dt;
					in_valid <= 1'b1;
					items_sent <= items_sent + 1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: compare each transfer with the oldest prediction; stall at random,
	// and twice hold off long enough for the block to back up its input.
	always @(posedge clk or negedge arst_n) begin : result_check
		track_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			results_seen <= 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (expected_track.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("result %0d not expected: position %h velocity %h status %b",
							results_seen, position, velocity, status);
					end
				end else begin
					want = expected_track.pop_front();
					if (position !== want.pos || velocity !== want.vel || status !== want.stat) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS) begin
							$display("result %0d: expected position %h velocity %h status %b",
								results_seen, want.pos, want.vel, want.stat);
							$display("result %0d:      got position %h velocity %h status %b",
								results_seen, position, velocity, status);
						end
					end
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (out_valid && out_ready && (results_seen == 250 || results_seen == 1100)) begin
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= (results_seen >= 700 && results_seen < 1000) ||
					($urandom_range(0, 99) >= 27);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic queue_sample(input logic op, input logic [COUNT_W-1:0] cnt,
			input logic [DT_W-1:0] dt);
		track_item_t it;
		it.op = op;
		it.count = cnt;
		it.dt = dt;
		pending_samples.push_back(it);
	endtask

	// Mostly a wrapped walk around one revolution, with resets and raw noise mixed in.
	task automatic queue_random(input int n);
		track_item_t it;
		logic [DT_W-1:0] dt_mask;
		int sel, cpr, lim, step;
		cpr = int'(trk_cpr);
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			dt_mask = {DT_W{1'b1}};
			dt_mask = dt_mask >> $urandom_range(0, DT_W - 1);
			it.dt = DT_W'($urandom) & dt_mask;
			it.op = KIND_UPDATE;
			if (sel < 6) begin
				it.op = KIND_RESET;
				it.count = COUNT_W'($urandom);
				walk_count = int'(it.count);
			end else if (sel < 16 || cpr == 0) begin
				it.count = COUNT_W'($urandom);
			end else begin
				lim = ($urandom_range(0, 9) < 7) ? cpr / 8 : cpr - 1;
				step = int'($urandom_range(0, lim));
				if ($urandom_range(0, 1) == 1) step = -step;
				walk_count = ((walk_count + step) % cpr + cpr) % cpr;
				it.count = COUNT_W'(walk_count);
			end
			pending_samples.push_back(it);
		end
	endtask

	task automatic drain_and_settle();
		while (pending_samples.size() != 0 || in_valid || expected_track.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cpr(input logic [COUNT_W-1:0] value);
		cfg_wr_data <= value;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		trk_cpr = value;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// counts per revolution at its reset value
		queue_sample(KIND_RESET, 16'd0, 24'd0);
		queue_sample(KIND_UPDATE, 16'd0, 24'd0);
		queue_sample(KIND_UPDATE, 16'd2049, 24'd1);
		queue_sample(KIND_UPDATE, 16'd0, 24'd1000);
		queue_sample(KIND_UPDATE, 16'd2048, 24'd500);
		queue_sample(KIND_UPDATE, 16'd0, 24'd7);
		queue_sample(KIND_UPDATE, 16'd4095, 24'hFFFFFF);
		queue_sample(KIND_UPDATE, 16'hFFFF, 24'hFFFFFF);
		queue_sample(KIND_UPDATE, 16'd0, 24'd1);
		queue_sample(KIND_RESET, 16'hFFFF, 24'd0);
		queue_sample(KIND_UPDATE, 16'd32768, 24'd12345);
		queue_random(300);
		drain_and_settle();

		// zero counts per revolution: updates rejected, resets still taken
		write_cpr(16'd0);
		queue_sample(KIND_UPDATE, 16'd100, 24'd1);
		queue_sample(KIND_RESET, 16'd1234, 24'd0);
		queue_sample(KIND_UPDATE, 16'd0, 24'hFFFFFF);
		queue_random(60);
		drain_and_settle();

		// one count per revolution: every move wraps, speeds clamp
		write_cpr(16'd1);
		queue_sample(KIND_RESET, 16'd0, 24'd0);
		queue_sample(KIND_UPDATE, 16'hFFFF, 24'd1);
		queue_sample(KIND_UPDATE, 16'd0, 24'd1);
		queue_sample(KIND_UPDATE, 16'd1, 24'hFFFFFF);
		queue_random(300);
		drain_and_settle();

		write_cpr(16'hFFFF);
		queue_sample(KIND_RESET, 16'd0, 24'd0);
		queue_sample(KIND_UPDATE, 16'hFFFF, 24'd3);
		queue_sample(KIND_UPDATE, 16'd32767, 24'd2);
		queue_sample(KIND_UPDATE, 16'd0, 24'd1);
		queue_random(300);
		drain_and_settle();

		write_cpr(16'd3);
		queue_random(230);
		drain_and_settle();

		write_cpr(COUNT_W'($urandom_range(4, 65534)));
		queue_random(230);
		drain_and_settle();

		write_cpr(16'd32768);
		queue_random(230);
		drain_and_settle();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_track.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
